### rtl/tmvp_pkg.sv
// Shared types and constants for the transposed matrix-vector product block.
`timescale 1ns / 1ps
`default_nettype none

package tmvp_pkg;

   // Fixed field widths
   localparam int VAL_W      = 16;
   localparam int PROD_W     = 2 * VAL_W;
   localparam int SUM_W      = 48;
   localparam int OUT_IDX_W  = 7;
   localparam int CSR_W      = 8;
   localparam int REQ_DATA_W = 2 * VAL_W;
   localparam int RSP_DATA_W = 56;

   // Size in use after reset
   localparam int SIZE_RESET = 128;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Position of an element within the matrix
   typedef struct packed {
      logic first_row;
      logic last_row;
      logic last_col;
   } tmvp_tag_type;

   localparam int TAG_W = $bits(tmvp_tag_type);

endpackage

`default_nettype wire

### rtl/tmvp_front.sv
// Front end: size register, row/column tracking, product and position tag.
`timescale 1ns / 1ps
`default_nettype none

module tmvp_front #(
   parameter int MAX_SIZE = 128,
   parameter int IDX_W    = 7
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wen,
   input  wire logic [tmvp_pkg::CSR_W-1:0]    csr_wdata,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [tmvp_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                          q_full,
   output logic                               q_push,
   output logic [tmvp_pkg::PROD_W-1:0]        push_prod,
   output logic [IDX_W-1:0]                   push_col,
   output tmvp_pkg::tmvp_tag_type             push_tag
);
   import tmvp_pkg::*;

   localparam int SZ_W = ($clog2(MAX_SIZE + 1) > CSR_W) ? $clog2(MAX_SIZE + 1) : CSR_W;
   localparam int RESET_SIZE = (SIZE_RESET > MAX_SIZE) ? MAX_SIZE : SIZE_RESET;
   localparam logic [IDX_W-1:0] RESET_LAST = IDX_W'(RESET_SIZE - 1);

   logic [IDX_W-1:0]    last_ff, last_in;
   logic [IDX_W-1:0]    row_ff, row_in;
   logic [IDX_W-1:0]    col_ff, col_in;
   logic [SZ_W-1:0]     wsize;
   logic signed [VAL_W-1:0]  mval;
   logic signed [VAL_W-1:0]  wval;
   logic signed [PROD_W-1:0] prod;
   logic                accept;

   // Clamp the written size to 1..MAX_SIZE, keep it as a last index
   always_comb begin
      wsize = SZ_W'(csr_wdata);
      if (wsize == '0) begin
         last_in = '0;
      end else if (wsize > SZ_W'(MAX_SIZE)) begin
         last_in = IDX_W'(MAX_SIZE - 1);
      end else begin
         last_in = IDX_W'(wsize - SZ_W'(1));
      end
   end

   assign req_tready = ~q_full;
   assign accept     = req_tvalid & req_tready;

   // Advance row and column in row-major order
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (col_ff == last_ff) begin
         col_in = '0;
         row_in = (row_ff == last_ff) ? '0 : row_ff + IDX_W'(1);
      end else begin
         col_in = col_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= RESET_LAST;
         row_ff  <= '0;
         col_ff  <= '0;
      end else if (csr_wen) begin
         last_ff <= last_in;
         row_ff  <= '0;
         col_ff  <= '0;
      end else if (accept) begin
         row_ff  <= row_in;
         col_ff  <= col_in;
      end
   end

   // Form the product and classify the element
   assign mval = req_tdata[VAL_W-1:0];
   assign wval = req_tdata[2*VAL_W-1:VAL_W];
   assign prod = mval * wval;

   assign q_push             = accept;
   assign push_prod          = prod;
   assign push_col           = col_ff;
   assign push_tag.first_row = (row_ff == '0);
   assign push_tag.last_row  = (row_ff == last_ff);
   assign push_tag.last_col  = (col_ff == last_ff);

endmodule

`default_nettype wire

### rtl/tmvp_queue.sv
// Short queue that decouples the front end from the accumulator back end.
`timescale 1ns / 1ps
`default_nettype none

module tmvp_queue #(
   parameter int WIDTH = 42
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      head_data,
   output logic                  q_valid,
   output logic                  q_full
);
   import tmvp_pkg::*;

   logic [WIDTH-1:0]  slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign q_valid   = (count_ff != '0);
   assign q_full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_data = slot_ff[rd_ptr_ff];

   // Track occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   // Store the incoming transaction
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/tmvp_back.sv
// Back end: column accumulator memory, accumulate stage and output register.
`timescale 1ns / 1ps
`default_nettype none

module tmvp_back #(
   parameter int MAX_SIZE = 128,
   parameter int IDX_W    = 7
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            q_valid,
   output logic                                 q_pop,
   input  wire logic [tmvp_pkg::PROD_W-1:0]     head_prod,
   input  wire logic [IDX_W-1:0]                head_col,
   input  wire tmvp_pkg::tmvp_tag_type          head_tag,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [tmvp_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast
);
   import tmvp_pkg::*;

   logic [SUM_W-1:0]  acc_mem [MAX_SIZE];
   logic [SUM_W-1:0]  rd_ff;

   logic              s1_valid_ff;
   logic [PROD_W-1:0] s1_prod_ff;
   logic [IDX_W-1:0]  s1_col_ff;
   tmvp_tag_type      s1_tag_ff;

   logic              out_valid_ff;
   logic [OUT_IDX_W-1:0] out_idx_ff;
   logic [SUM_W-1:0]  out_sum_ff;
   logic              out_last_ff;

   logic              out_free;
   logic              s1_go;
   logic [SUM_W-1:0]  prod_ext;
   logic [SUM_W-1:0]  sum;

   assign out_free = ~out_valid_ff | rsp_tready;
   assign s1_go    = s1_valid_ff & (~s1_tag_ff.last_row | out_free);
   assign q_pop    = q_valid & (~s1_valid_ff | s1_go);

   // Overwrite on the first row, add on later rows
   assign prod_ext = {{(SUM_W - PROD_W){s1_prod_ff[PROD_W-1]}}, s1_prod_ff};
   assign sum      = s1_tag_ff.first_row ? prod_ext : rd_ff + prod_ext;

   // Read on entry to the stage, write back as it leaves; consecutive
   // elements only share a column for a one-by-one matrix, which never uses the read
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rd_ff <= acc_mem[head_col];
      end
      if (s1_go) begin
         acc_mem[s1_col_ff] <= sum;
      end
   end

   // Accumulate stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (q_pop) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_prod_ff <= head_prod;
         s1_col_ff  <= head_col;
         s1_tag_ff  <= head_tag;
      end
   end

   // Output register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_go && s1_tag_ff.last_row) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_tag_ff.last_row) begin
         out_idx_ff  <= OUT_IDX_W'(s1_col_ff);
         out_sum_ff  <= sum;
         out_last_ff <= s1_tag_ff.last_col;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - SUM_W - OUT_IDX_W){1'b0}}, out_sum_ff, out_idx_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

### rtl/transposed_matrix_vector_product_top.sv
// Top level of the transposed matrix-vector product block.
`timescale 1ns / 1ps
`default_nettype none

// Streams a square matrix in row-major order, one element per transaction with
// its row's weight, and returns the weighted column sums during the last row,
// one per element, tlast on the final column. Sustained rate is one element
// per cycle while the response side does not stall, set by the single
// read-modify-write of the column accumulator memory per element; after its
// element is accepted, a result passes the queue, the accumulate stage and
// the output register in that order. Writing the size register restarts the
// matrix at row 0, column 0; sizes of zero act as one and sizes above MAX_SIZE
// act as MAX_SIZE. Write the register only while no element is in flight.
module transposed_matrix_vector_product_top #(
   parameter int MAX_SIZE = 128
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wen,
   input  wire logic [7:0]   csr_wdata,   // size_in_use
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [31:0]  req_tdata,   // matrix_value [15:0], row_weight [31:16]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [55:0]       rsp_tdata,   // column_index [6:0], column_sum [54:7], zero [55]
   output logic              rsp_tlast    // last_column
);
   import tmvp_pkg::*;

   localparam int IDX_W = $clog2(MAX_SIZE);
   localparam int QW    = PROD_W + IDX_W + TAG_W;

   logic              q_push;
   logic              q_pop;
   logic              q_valid;
   logic              q_full;
   logic [PROD_W-1:0] push_prod;
   logic [IDX_W-1:0]  push_col;
   tmvp_tag_type      push_tag;
   logic [QW-1:0]     head_data;
   logic [PROD_W-1:0] head_prod;
   logic [IDX_W-1:0]  head_col;
   tmvp_tag_type      head_tag;

   tmvp_front #(
      .MAX_SIZE (MAX_SIZE),
      .IDX_W    (IDX_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .push_prod  (push_prod),
      .push_col   (push_col),
      .push_tag   (push_tag)
   );

   tmvp_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_tag, push_col, push_prod}),
      .pop       (q_pop),
      .head_data (head_data),
      .q_valid   (q_valid),
      .q_full    (q_full)
   );

   assign head_prod = head_data[PROD_W-1:0];
   assign head_col  = head_data[PROD_W+IDX_W-1:PROD_W];
   assign head_tag  = head_data[QW-1:PROD_W+IDX_W];

   tmvp_back #(
      .MAX_SIZE (MAX_SIZE),
      .IDX_W    (IDX_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .head_prod  (head_prod),
      .head_col   (head_col),
      .head_tag   (head_tag),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Back end never pops an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   // Front end never pushes into a full queue
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue pushed while full");

   // A transaction pushed into an empty queue is visible next cycle
   a_push_seen: assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_valid) |=> q_valid)
      else $error("pushed transaction lost");

endmodule

`default_nettype wire
